FILE: rtl/bhtdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed hash table package
// Shared sizes, request codes and the entry, row and queued item types.
// ----------------------------------------------------------------------------
package bhtdr_pkg;

  localparam int BKT_TOTAL = 1024;
  localparam int WAYS      = 4;
  localparam int BKT_W     = $clog2(BKT_TOTAL);
  localparam int CNT_W     = 11;
  localparam int KEY_W     = 64;

  localparam logic [1:0] REQ_STORE = 2'd0;
  localparam logic [1:0] REQ_PROBE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [15:0]      eval_v;
    logic [15:0]      move_v;
    logic [7:0]       depth_v;
    logic [1:0]       bound_v;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic [1:0]       req;
    logic [BKT_W-1:0] bucket;
    entry_t           data;
  } item_t;

endpackage
`default_nettype wire

FILE: rtl/bucketed_hash_table_depth_replace.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed hash table with depth-preferred replacement
// Set-associative store of search results, 1024 buckets of 4 ways.
// ----------------------------------------------------------------------------
// Usage: raise start with req_type, key and the store fields; the beat is
// taken on a clock edge where busy is low. Each request gives exactly one
// result beat, marked by done for a single cycle; the receiver cannot stall.
// A store or probe waits in the queue, its row is read into rd_row as it
// leaves, and the look state then compares and writes back on the
// single-port bucket memory; the back end takes the next queued request
// only after that look state. Clear answers as soon as it leaves the queue
// and then sweeps the memory one row a cycle, during which queued requests
// wait. After reset the same sweep runs; up to two requests are queued
// meanwhile and busy then stays high. The user must write bucket_count
// through cfg_we/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module bucketed_hash_table_depth_replace (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [bhtdr_pkg::CNT_W-1:0] cfg_wdata,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  req_type,
  input  wire logic [bhtdr_pkg::KEY_W-1:0] key,
  input  wire logic signed [15:0]          eval_in,
  input  wire logic [15:0]                 move_in,
  input  wire logic [7:0]                  depth_in,
  input  wire logic [1:0]                  bound_in,
  output logic                             done,
  output logic                             hit,
  output logic signed [15:0]               eval_out,
  output logic [15:0]                      move_out,
  output logic [7:0]                       depth_out,
  output logic [1:0]                       bound_out
);

  logic             q_valid;
  logic             q_pop;
  bhtdr_pkg::item_t q_item;

  bhtdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .req_type  (req_type),
    .key       (key),
    .eval_in   (eval_in),
    .move_in   (move_in),
    .depth_in  (depth_in),
    .bound_in  (bound_in),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  bhtdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .done      (done),
    .hit       (hit),
    .eval_out  (eval_out),
    .move_out  (move_out),
    .depth_out (depth_out),
    .bound_out (bound_out)
  );

endmodule
`default_nettype wire

FILE: rtl/bhtdr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed hash table front end
// Holds the bucket count, maps each accepted key to its bucket and queues it.
// ----------------------------------------------------------------------------
module bhtdr_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [bhtdr_pkg::CNT_W-1:0]       cfg_wdata,
  input  wire logic                              start,
  input  wire logic [1:0]                        req_type,
  input  wire logic [bhtdr_pkg::KEY_W-1:0]       key,
  input  wire logic signed [15:0]                eval_in,
  input  wire logic [15:0]                       move_in,
  input  wire logic [7:0]                        depth_in,
  input  wire logic [1:0]                        bound_in,
  output logic                                   busy,
  output logic                                   q_valid,
  output bhtdr_pkg::item_t                       q_item,
  input  wire logic                              q_pop
);

  localparam int PROD_W = bhtdr_pkg::KEY_W + bhtdr_pkg::CNT_W;

  logic [bhtdr_pkg::CNT_W-1:0] bucket_count;
  logic [bhtdr_pkg::CNT_W-1:0] used;
  logic [PROD_W-1:0]           prod;
  logic [bhtdr_pkg::CNT_W-1:0] hi;
  logic [bhtdr_pkg::BKT_W-1:0] bucket;
  bhtdr_pkg::item_t            q [2];
  logic [1:0]                  cnt;
  logic                        wp, rp, push;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= bhtdr_pkg::CNT_W'(bhtdr_pkg::BKT_TOTAL);
    end else if (cfg_we) begin
      bucket_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (bucket_count == '0) begin
      used = bhtdr_pkg::CNT_W'(1);
    end else if (bucket_count > bhtdr_pkg::CNT_W'(bhtdr_pkg::BKT_TOTAL)) begin
      used = bhtdr_pkg::CNT_W'(bhtdr_pkg::BKT_TOTAL);
    end else begin
      used = bucket_count;
    end
    // The bucket is the top part of key times the bucket count (0 taken as 1, above 1024 as 1024).
    prod = PROD_W'(key) * PROD_W'(used);
    hi   = prod[PROD_W-1:bhtdr_pkg::KEY_W];
    if (hi >= bhtdr_pkg::CNT_W'(bhtdr_pkg::BKT_TOTAL)) begin
      bucket = bhtdr_pkg::BKT_W'(bhtdr_pkg::BKT_TOTAL - 1);
    end else begin
      bucket = hi[bhtdr_pkg::BKT_W-1:0];
    end
  end

  assign busy    = (cnt == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt != 2'd0);
  assign q_item  = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp].req          <= req_type;
      q[wp].bucket       <= bucket;
      q[wp].data.key     <= key;
      q[wp].data.eval_v  <= $unsigned(eval_in);
      q[wp].data.move_v  <= move_in;
      q[wp].data.depth_v <= depth_in;
      q[wp].data.bound_v <= bound_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (q_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bhtdr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed hash table back end
// Owns the bucket memory, clears it, and runs stores and probes on one row.
// ----------------------------------------------------------------------------
module bhtdr_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire bhtdr_pkg::item_t  q_item,
  output logic                   q_pop,
  output logic                   done,
  output logic                   hit,
  output logic signed [15:0]     eval_out,
  output logic [15:0]            move_out,
  output logic [7:0]             depth_out,
  output logic [1:0]             bound_out
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;

  localparam int WAY_W = (bhtdr_pkg::WAYS > 1) ? $clog2(bhtdr_pkg::WAYS) : 1;

  bhtdr_pkg::row_t             mem [bhtdr_pkg::BKT_TOTAL];
  bhtdr_pkg::row_t             rd_row;
  bhtdr_pkg::row_t             new_row;
  bhtdr_pkg::item_t            cur;
  logic [1:0]                  st;
  logic [bhtdr_pkg::BKT_W-1:0] sweep;
  logic                        we;
  logic [bhtdr_pkg::BKT_W-1:0] wa;
  bhtdr_pkg::row_t             wd;
  logic [WAY_W-1:0]            pick, hway;
  logic [7:0]                  lowest;
  logic                        found, phit;

  assign q_pop = (st == ST_IDLE) && q_valid;

  // Way choice: first matching or empty way, else the strictly shallowest.
  always_comb begin
    pick   = '0;
    lowest = rd_row[0].depth_v;
    found  = 1'b0;
    hway   = '0;
    phit   = 1'b0;
    for (int w = 0; w < bhtdr_pkg::WAYS; w++) begin
      if (!found) begin
        if (rd_row[w].key == cur.data.key || rd_row[w].key == '0) begin
          pick  = WAY_W'(w);
          found = 1'b1;
        end else if (rd_row[w].depth_v < lowest) begin
          lowest = rd_row[w].depth_v;
          pick   = WAY_W'(w);
        end
      end
      if (!phit && rd_row[w].key == cur.data.key) begin
        hway = WAY_W'(w);
        phit = 1'b1;
      end
    end
    new_row       = rd_row;
    new_row[pick] = cur.data;
  end

  assign we = (st == ST_CLR) || (st == ST_LOOK && cur.req == bhtdr_pkg::REQ_STORE);
  assign wa = (st == ST_CLR) ? sweep : cur.bucket;
  assign wd = (st == ST_CLR) ? '0 : new_row;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (q_pop) begin
      rd_row <= mem[q_item.bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_CLR;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        ST_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == bhtdr_pkg::BKT_W'(bhtdr_pkg::BKT_TOTAL - 1)) begin
            st <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            if (q_item.req inside {bhtdr_pkg::REQ_STORE, bhtdr_pkg::REQ_PROBE}) begin
              st <= ST_LOOK;
            end else begin
              // Clear and the unused code answer at once with a zero beat.
              done <= 1'b1;
              if (q_item.req == bhtdr_pkg::REQ_CLEAR) begin
                st    <= ST_CLR;
                sweep <= '0;
              end
            end
          end
        end
        ST_LOOK: begin
          done <= 1'b1;
          st   <= ST_IDLE;
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_LOOK && cur.req == bhtdr_pkg::REQ_PROBE && phit) begin
      hit       <= 1'b1;
      eval_out  <= $signed(rd_row[hway].eval_v);
      move_out  <= rd_row[hway].move_v;
      depth_out <= rd_row[hway].depth_v;
      bound_out <= rd_row[hway].bound_v;
    end else begin
      hit       <= 1'b0;
      eval_out  <= '0;
      move_out  <= '0;
      depth_out <= '0;
      bound_out <= '0;
    end
  end

`ifndef SYNTH
  a_done_not_in_clear: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(st) != ST_CLR) else $error("result beat while clearing");
  a_hit_is_probe: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> cur.req == bhtdr_pkg::REQ_PROBE) else $error("hit on non-probe");
  a_sweep_steps: assert property (@(posedge clk) disable iff (rst)
    (st == ST_CLR && $past(st) == ST_CLR && !$past(rst)) |-> sweep == $past(sweep) + 1'b1)
    else $error("clear sweep skipped a row");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_bucketed_hash_table_depth_replace.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the bucketed hash table with depth-preferred replacement
// Drives store, probe and clear requests under several bucket counts. A
// behavioural copy of the table predicts every result beat, and each result
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic        hit;
  logic [15:0] eval_v;
  logic [15:0] move_v;
  logic [7:0]  depth_v;
  logic [1:0]  bound_v;
} answer_t;

class table_scoreboard;
  logic [63:0] tkey [bhtdr_pkg::BKT_TOTAL*bhtdr_pkg::WAYS];
  logic [15:0] teval [bhtdr_pkg::BKT_TOTAL*bhtdr_pkg::WAYS];
  logic [15:0] tmove [bhtdr_pkg::BKT_TOTAL*bhtdr_pkg::WAYS];
  logic [7:0]  tdepth [bhtdr_pkg::BKT_TOTAL*bhtdr_pkg::WAYS];
  logic [1:0]  tbound [bhtdr_pkg::BKT_TOTAL*bhtdr_pkg::WAYS];
  logic [10:0] buckets;
  answer_t     pending [$];
  int          mismatches;
  int          checked;
  int          hits;

  function void wipe();
    for (int i = 0; i < bhtdr_pkg::BKT_TOTAL*bhtdr_pkg::WAYS; i++) begin
      tkey[i] = '0; teval[i] = '0; tmove[i] = '0; tdepth[i] = '0; tbound[i] = '0;
    end
  endfunction

  function new();
    wipe();
    buckets = 11'd1024;
    pending = {};
    mismatches = 0;
    checked = 0;
    hits = 0;
  endfunction

  function int bucket_for(logic [63:0] k);
    logic [127:0] prod;
    int n;
    n = (buckets == 0) ? 1 :
        (buckets > bhtdr_pkg::BKT_TOTAL ? bhtdr_pkg::BKT_TOTAL : int'(buckets));
    prod = 128'(k) * 128'(n);
    return (prod[127:64] >= bhtdr_pkg::BKT_TOTAL) ? bhtdr_pkg::BKT_TOTAL - 1
                                                  : int'(prod[127:64]);
  endfunction

  function void note_request(logic [1:0] rq, logic [63:0] k, logic [15:0] ev,
                             logic [15:0] mv, logic [7:0] dp, logic [1:0] bd);
    answer_t a;
    int base;
    int pick;
    logic [7:0] lowest;
    a = '0;
    base = bucket_for(k) * bhtdr_pkg::WAYS;
    if (rq == bhtdr_pkg::REQ_STORE) begin
      pick = base;
      lowest = tdepth[base];
      for (int w = 0; w < bhtdr_pkg::WAYS; w++) begin
        if (tkey[base+w] == k || tkey[base+w] == 0) begin
          pick = base + w;
          break;
        end
        if (tdepth[base+w] < lowest) begin
          lowest = tdepth[base+w];
          pick = base + w;
        end
      end
      tkey[pick] = k; teval[pick] = ev; tmove[pick] = mv;
      tdepth[pick] = dp; tbound[pick] = bd;
    end else if (rq == bhtdr_pkg::REQ_PROBE) begin
      for (int w = 0; w < bhtdr_pkg::WAYS; w++) begin
        if (tkey[base+w] == k) begin
          a = {1'b1, teval[base+w], tmove[base+w], tdepth[base+w], tbound[base+w]};
          break;
        end
      end
    end else if (rq == bhtdr_pkg::REQ_CLEAR) begin
      wipe();
    end
    pending.push_back(a);
  endfunction

  function void check_result(answer_t got);
    answer_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h", got);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (want.hit) hits++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: hit %b/%b eval %h/%h move %h/%h depth %h/%h bound %h/%h",
                 want.hit, got.hit, want.eval_v, got.eval_v, want.move_v, got.move_v,
                 want.depth_v, got.depth_v, want.bound_v, got.bound_v);
    end
  endfunction
endclass

module tb_bucketed_hash_table_depth_replace;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [63:0] key = '0;
  logic signed [15:0] eval_in = '0;
  logic [15:0] move_in = '0;
  logic [7:0]  depth_in = '0;
  logic [1:0]  bound_in = '0;
  logic        done;
  logic        hit;
  logic signed [15:0] eval_out;
  logic [15:0] move_out;
  logic [7:0]  depth_out;
  logic [1:0]  bound_out;

  table_scoreboard board = new();
  int     cycles = 0;
  int     gap_pct = 24;
  int     sent = 0;
  logic [63:0] known_keys [$];

  bucketed_hash_table_depth_replace u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy), .req_type(req_type), .key(key),
    .eval_in(eval_in), .move_in(move_in), .depth_in(depth_in),
    .bound_in(bound_in), .done(done), .hit(hit), .eval_out(eval_out),
    .move_out(move_out), .depth_out(depth_out), .bound_out(bound_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done)
      board.check_result({hit, eval_out, move_out, depth_out, bound_out});
    if (cycles > 600000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The beat is taken at the edge where start is high and busy low. Start
  // stays high into the next send unless the sender idles first.
  task automatic send(logic [1:0] rq, logic [63:0] k, logic [15:0] ev,
                      logic [15:0] mv, logic [7:0] dp, logic [1:0] bd);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1; req_type <= rq; key <= k; eval_in <= ev;
    move_in <= mv; depth_in <= dp; bound_in <= bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(rq, k, ev, mv, dp, bd);
    sent++;
    if (rq == bhtdr_pkg::REQ_STORE && known_keys.size() < 200) known_keys.push_back(k);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    // A clear still sweeps the table after its answer; let it finish.
    repeat (1100) @(posedge clk);
  endtask

  task automatic set_buckets(logic [10:0] n);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.buckets = n;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count);
    logic [63:0] k;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (known_keys.size() != 0 && $urandom_range(1))
        k = known_keys[$urandom_range(known_keys.size()-1)];
      else if ($urandom_range(9) == 0)
        k = {2'($urandom_range(3)), 62'd0} | 64'($urandom_range(3));
      else
        k = rand64();
      if (r < 45)
        send(bhtdr_pkg::REQ_STORE, k, 16'($urandom), 16'($urandom), 8'($urandom),
             2'($urandom));
      else if (r < 97)
        send(bhtdr_pkg::REQ_PROBE, k, 16'($urandom), 16'($urandom), 8'($urandom),
             2'($urandom));
      else if (r < 98)
        send(bhtdr_pkg::REQ_SPARE, k, 16'($urandom), 16'($urandom), 8'($urandom),
             2'($urandom));
      else begin
        send(bhtdr_pkg::REQ_CLEAR, k, '0, '0, '0, '0);
        known_keys = {};
      end
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed: extremes, every request code, key zero and the full bucket.
    send(bhtdr_pkg::REQ_PROBE, 64'd0, '0, '0, '0, '0);
    send(bhtdr_pkg::REQ_STORE, 64'd0, 16'h7fff, 16'hffff, 8'hff, 2'd3);
    send(bhtdr_pkg::REQ_PROBE, 64'd0, '0, '0, '0, '0);
    send(bhtdr_pkg::REQ_STORE, '1, 16'h8000, 16'h0000, 8'h00, 2'd0);
    send(bhtdr_pkg::REQ_PROBE, '1, '0, '0, '0, '0);
    for (int w = 0; w < 6; w++)
      send(bhtdr_pkg::REQ_STORE, 64'h0000_0000_0000_1000 + 64'(w), 16'(w), 16'(w),
           8'(5 - w % 3), 2'(w));
    for (int w = 0; w < 6; w++)
      send(bhtdr_pkg::REQ_PROBE, 64'h0000_0000_0000_1000 + 64'(w), '0, '0, '0, '0);
    send(bhtdr_pkg::REQ_SPARE, '1, '1, '1, '1, '1);
    send(bhtdr_pkg::REQ_CLEAR, '0, '0, '0, '0, '0);
    send(bhtdr_pkg::REQ_PROBE, '1, '0, '0, '0, '0);
    send(bhtdr_pkg::REQ_PROBE, 64'd0, '0, '0, '0, '0);
    known_keys = {};
    set_buckets(11'd1);
    random_phase(200);
    set_buckets(11'd0);
    random_phase(100);
    set_buckets(11'd2047);
    random_phase(250);
    gap_pct = 60;
    set_buckets(11'd3);
    random_phase(250);
    gap_pct = 0;
    set_buckets(11'd1024);
    random_phase(250);
    set_buckets(11'd17);
    random_phase(230);
    drain();
    $display("run: %0d requests, %0d results checked, %0d probe hits",
             sent, board.checked, board.hits);
    $display("bucket counts 0, 1, 3, 17, 1024 and 2047 with clears and code 3");
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
